/* hdl/i2c_master_transaction_engine_macros.svh */
// Assertion macros shared by the I2C master transaction engine RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising clock edge, off while reset is asserted.
`define I2CMTE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cmte check failed");
// Check prop on every rising clock edge, reset included.
`define I2CMTE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2cmte check failed");
`else
`define I2CMTE_ASSERT(lbl, clk, rst_n, prop)
`define I2CMTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hdl/i2cmte_pkg.sv */
// Shared types and codes for the I2C master transaction engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2cmte_pkg;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  // transaction kinds
  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_READ     = 2'd1;
  localparam logic [1:0] MODE_REG_READ = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  // completion status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_START_FAIL = 2'd1;
  localparam logic [1:0] ST_NO_ACK     = 2'd2;

  typedef struct packed {
    logic       op;
    logic [1:0] mode;
    logic [7:0] dev_addr;
    logic [7:0] length;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

/* hdl/i2cmte_in_reg.sv */
// Input register stage of the I2C master transaction engine.
// Depends on i2cmte_pkg for the request type.
`timescale 1ns / 1ps

module i2cmte_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2cmte_pkg::item_t  item_i,
  input  logic               take_i,
  output logic               valid_o,
  output i2cmte_pkg::item_t  item_o
);

  logic              valid_q, valid_d;
  i2cmte_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload loads on every accepted request
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/i2cmte_seq.sv */
// Bus sequencer of the I2C master transaction engine: transaction state
// and the one-step next-state logic. Depends on i2cmte_pkg and the macros.
`timescale 1ns / 1ps
`include "i2c_master_transaction_engine_macros.svh"

module i2cmte_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  i2cmte_pkg::item_t   item_i,
  output i2cmte_pkg::result_t res_o
);

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_START        = 4'd1;
  localparam logic [3:0] PH_SEND_ADDR    = 4'd2;
  localparam logic [3:0] PH_SEND_REG     = 4'd3;
  localparam logic [3:0] PH_SEND_DATA    = 4'd4;
  localparam logic [3:0] PH_WACK_ADDR    = 4'd5;
  localparam logic [3:0] PH_WACK_REG     = 4'd6;
  localparam logic [3:0] PH_WACK_DATA    = 4'd7;
  localparam logic [3:0] PH_STOP_OK      = 4'd8;
  localparam logic [3:0] PH_STOP_NACK    = 4'd9;
  localparam logic [3:0] PH_STOP_RESTART = 4'd10;
  localparam logic [3:0] PH_RECV         = 4'd11;
  localparam logic [3:0] PH_MACK         = 4'd12;

  logic [3:0] phase_q, phase_d;
  logic [1:0] quant_q, quant_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] bytes_q, bytes_d;
  logic [7:0] shift_q, shift_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] reg_q, reg_d;
  logic       restart_q, restart_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  always_comb begin
    logic       scl;
    logic       sda;
    logic       taken;
    logic       rxv;
    logic [7:0] rxb;
    logic       rxl;
    logic       done;
    logic [1:0] st;
    logic       dos;
    logic [7:0] dos_bytes;
    logic       mack_lvl;
    logic [7:0] shift_in;

    phase_d   = phase_q;
    quant_d   = quant_q;
    bit_d     = bit_q;
    bytes_d   = bytes_q;
    shift_d   = shift_q;
    kind_d    = kind_q;
    addr_d    = addr_q;
    reg_d     = reg_q;
    restart_d = restart_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    scl       = scl_q;
    sda       = sda_q;
    taken     = 1'b0;
    rxv       = 1'b0;
    rxb       = 8'd0;
    rxl       = 1'b0;
    done      = 1'b0;
    st        = i2cmte_pkg::ST_OK;
    dos       = 1'b0;
    dos_bytes = bytes_q;
    mack_lvl  = (bytes_q == 8'd1);
    shift_in  = {shift_q[6:0], item_i.sda_in};

    if (item_i.op == i2cmte_pkg::OP_BEGIN) begin
      // a begin while busy, or of the reserved kind, is dropped
      if (phase_q == PH_IDLE && item_i.mode != i2cmte_pkg::MODE_RSVD) begin
        kind_d    = item_i.mode;
        addr_d    = item_i.dev_addr;
        reg_d     = item_i.tx_byte;
        bytes_d   = item_i.length;
        restart_d = 1'b0;
        shift_d   = 8'd0;
        phase_d   = PH_START;
        bit_d     = 3'd0;
        quant_d   = 2'd0;
      end
    end else if (phase_q != PH_IDLE) begin
      case (phase_q)
        PH_START: begin
          scl = 1'b1;
          if (quant_q == 2'd0) begin
            sda = 1'b1;
            if (!restart_q && !item_i.sda_in) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              st      = i2cmte_pkg::ST_START_FAIL;
            end else begin
              quant_d = 2'd1;
            end
          end else if (quant_q == 2'd1) begin
            sda = 1'b0;
            if (!restart_q && item_i.sda_in) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              st      = i2cmte_pkg::ST_START_FAIL;
            end else begin
              quant_d = 2'd2;
            end
          end else begin
            sda     = 1'b0;
            phase_d = PH_SEND_ADDR;
            bit_d   = 3'd0;
            quant_d = 2'd0;
            shift_d = (restart_q || kind_q == i2cmte_pkg::MODE_READ) ?
                      addr_q + 8'd1 : addr_q;
          end
        end
        PH_SEND_ADDR, PH_SEND_REG, PH_SEND_DATA: begin
          if (quant_q == 2'd0) begin
            scl     = 1'b0;
            quant_d = 2'd1;
            // latch write data on the first quantum of each byte
            if (phase_q == PH_SEND_DATA && bit_q == 3'd0) begin
              shift_d = item_i.tx_byte;
              taken   = 1'b1;
            end
          end else if (quant_q == 2'd1) begin
            scl     = 1'b0;
            sda     = shift_q[7];
            quant_d = 2'd2;
          end else begin
            scl     = 1'b1;
            sda     = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_q + 3'd1;
            quant_d = 2'd0;
            if (bit_q == 3'd7) begin
              bit_d = 3'd0;
              case (phase_q)
                PH_SEND_ADDR: phase_d = PH_WACK_ADDR;
                PH_SEND_REG:  phase_d = PH_WACK_REG;
                default:      phase_d = PH_WACK_DATA;
              endcase
            end
          end
        end
        PH_WACK_ADDR, PH_WACK_REG, PH_WACK_DATA: begin
          if (quant_q == 2'd0) begin
            scl     = 1'b0;
            quant_d = 2'd1;
          end else if (quant_q == 2'd1) begin
            scl     = 1'b0;
            sda     = 1'b1;
            quant_d = 2'd2;
          end else if (quant_q == 2'd2) begin
            scl     = 1'b1;
            sda     = 1'b1;
            quant_d = 2'd3;
          end else begin
            scl     = 1'b1;
            sda     = 1'b1;
            bit_d   = 3'd0;
            quant_d = 2'd0;
            if (phase_q == PH_WACK_ADDR) begin
              // restart address ack is clocked but not checked
              if (restart_q) begin
                dos = 1'b1;
              end else if (item_i.sda_in) begin
                phase_d = PH_STOP_NACK;
              end else if (kind_q == i2cmte_pkg::MODE_REG_READ) begin
                phase_d = PH_SEND_REG;
                shift_d = reg_q;
              end else begin
                dos = 1'b1;
              end
            end else if (phase_q == PH_WACK_REG) begin
              phase_d = item_i.sda_in ? PH_STOP_NACK : PH_STOP_RESTART;
            end else begin
              // data nack ignored
              dos       = 1'b1;
              dos_bytes = bytes_q - 8'd1;
            end
          end
        end
        PH_STOP_OK, PH_STOP_NACK, PH_STOP_RESTART: begin
          if (quant_q == 2'd0) begin
            scl     = 1'b0;
            quant_d = 2'd1;
          end else if (quant_q == 2'd1) begin
            scl     = 1'b0;
            sda     = 1'b0;
            quant_d = 2'd2;
          end else if (quant_q == 2'd2) begin
            scl     = 1'b1;
            sda     = 1'b0;
            quant_d = 2'd3;
          end else begin
            scl     = 1'b1;
            sda     = 1'b1;
            bit_d   = 3'd0;
            quant_d = 2'd0;
            if (phase_q == PH_STOP_RESTART) begin
              restart_d = 1'b1;
              phase_d   = PH_START;
            end else begin
              done    = 1'b1;
              st      = (phase_q == PH_STOP_NACK) ? i2cmte_pkg::ST_NO_ACK :
                                                    i2cmte_pkg::ST_OK;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_RECV: begin
          sda = 1'b1;
          if (quant_q == 2'd0) begin
            scl     = 1'b0;
            quant_d = 2'd1;
          end else begin
            scl     = 1'b1;
            shift_d = shift_in;
            bit_d   = bit_q + 3'd1;
            quant_d = 2'd0;
            if (bit_q == 3'd7) begin
              rxv     = 1'b1;
              rxb     = shift_in;
              rxl     = (bytes_q == 8'd1);
              bit_d   = 3'd0;
              phase_d = PH_MACK;
            end
          end
        end
        PH_MACK: begin
          // ack every byte but the last, which is nacked
          if (quant_q == 2'd0) begin
            scl     = 1'b0;
            quant_d = 2'd1;
          end else if (quant_q == 2'd1) begin
            scl     = 1'b0;
            sda     = mack_lvl;
            quant_d = 2'd2;
          end else if (quant_q == 2'd2) begin
            scl     = 1'b1;
            sda     = mack_lvl;
            quant_d = 2'd3;
          end else begin
            scl       = 1'b0;
            sda       = mack_lvl;
            bit_d     = 3'd0;
            quant_d   = 2'd0;
            dos       = 1'b1;
            dos_bytes = bytes_q - 8'd1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          bit_d   = 3'd0;
          quant_d = 2'd0;
        end
      endcase

      // move to the next data byte, or to the stop when none is left
      if (dos) begin
        bytes_d = dos_bytes;
        if (dos_bytes != 8'd0) begin
          shift_d = 8'd0;
          phase_d = (kind_q == i2cmte_pkg::MODE_WRITE) ? PH_SEND_DATA : PH_RECV;
        end else begin
          phase_d = PH_STOP_OK;
        end
      end

      scl_d = scl;
      sda_d = sda;
    end

    res_o.scl      = scl;
    res_o.sda_out  = sda;
    res_o.busy_res = (phase_d != PH_IDLE);
    res_o.tx_taken = taken;
    res_o.rx_valid = rxv;
    res_o.rx_byte  = rxb;
    res_o.rx_last  = rxl;
    res_o.done_res = done;
    res_o.status   = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      quant_q   <= 2'd0;
      bit_q     <= 3'd0;
      bytes_q   <= 8'd0;
      shift_q   <= 8'd0;
      kind_q    <= 2'd0;
      addr_q    <= 8'd0;
      reg_q     <= 8'd0;
      restart_q <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      quant_q   <= quant_d;
      bit_q     <= bit_d;
      bytes_q   <= bytes_d;
      shift_q   <= shift_d;
      kind_q    <= kind_d;
      addr_q    <= addr_d;
      reg_q     <= reg_d;
      restart_q <= restart_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  `I2CMTE_ASSERT(a_done_to_idle, clk_i, rst_ni, advance_i && res_o.done_res |=> phase_q == PH_IDLE)
  `I2CMTE_ASSERT(a_rx_from_recv, clk_i, rst_ni, res_o.rx_valid |-> phase_q == PH_RECV && quant_q == 2'd1)
  `I2CMTE_ASSERT(a_taken_in_data, clk_i, rst_ni, res_o.tx_taken |-> phase_q == PH_SEND_DATA && bit_q == 3'd0)
  `I2CMTE_ASSERT(a_hold_on_stall, clk_i, rst_ni, !advance_i |=> $stable(phase_q) && $stable(quant_q) && $stable(bytes_q))

endmodule

/* hdl/i2cmte_out_reg.sv */
// Result register of the I2C master transaction engine.
// Depends on i2cmte_pkg for the result type.
`timescale 1ns / 1ps

module i2cmte_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  i2cmte_pkg::result_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cmte_pkg::result_t res_o
);

  logic                valid_q, valid_d;
  i2cmte_pkg::result_t res_q;

  // free when empty or the held result leaves this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* hdl/i2c_master_transaction_engine.sv */
// I2C master transaction engine: bit-banged open-drain master, one bus
// quantum per tick request. Throughput is one request per clock while the result
// register has room; each request passes the input register, one sequencer
// step and the result register. The sequencer step that updates the transaction
// state is the loop that sets this rate. A begin request (op 1) starts write,
// read or register-read transactions when idle; a tick request (op 0) in a
// transaction drives SCL/SDA for one quantum and may sample sda_in_i. Depends
// on i2cmte_pkg, i2cmte_in_reg, i2cmte_seq and i2cmte_out_reg.
`timescale 1ns / 1ps

module i2c_master_transaction_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] dev_addr_i,
  input  logic [7:0] length_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       tx_taken_o,
  output logic       rx_valid_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_last_o,
  output logic       done_res_o,
  output logic [1:0] status_o
);

  i2cmte_pkg::item_t   in_item;
  i2cmte_pkg::item_t   stage_item;
  i2cmte_pkg::result_t step_res;
  i2cmte_pkg::result_t out_res;
  logic                stage_valid;
  logic                out_free;
  logic                advance;

  assign in_item.op       = op_i;
  assign in_item.mode     = mode_i;
  assign in_item.dev_addr = dev_addr_i;
  assign in_item.length   = length_i;
  assign in_item.tx_byte  = tx_byte_i;
  assign in_item.sda_in   = sda_in_i;

  // step the sequencer when a request waits and the result register has room
  assign advance = stage_valid && out_free;

  i2cmte_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  i2cmte_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .res_o     (step_res)
  );

  i2cmte_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign scl_o      = out_res.scl;
  assign sda_out_o  = out_res.sda_out;
  assign busy_res_o = out_res.busy_res;
  assign tx_taken_o = out_res.tx_taken;
  assign rx_valid_o = out_res.rx_valid;
  assign rx_byte_o  = out_res.rx_byte;
  assign rx_last_o  = out_res.rx_last;
  assign done_res_o = out_res.done_res;
  assign status_o   = out_res.status;

endmodule
